// ===== rtl/sbne_pkg.sv =====
// shared constants, types and codes for the segment box nearest entry block
package sbne_pkg;

  localparam int CoordBits = 32;
  localparam int TolBits   = 16;
  localparam int TBits     = 17;
  localparam int CfgIdxBits = 3;

  // t in q1.16
  localparam logic [TBits-1:0] TOne = TBits'(65536);
  localparam logic [TBits+1:0] TSat = (TBits+2)'(3 * 65536);

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegStartX = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegStartY = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegStartZ = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegEndX   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegEndY   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegEndZ   = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegTol    = 3'd6;

  // width of a difference of two coordinates
  localparam int DiffBits = CoordBits + 1;
  // quotient magnitude bits: integer part below 4 plus 16 fraction bits
  localparam int QBits    = 18;
  localparam int DivCntBits = $clog2(DiffBits + 17);

  // divider request and reply
  typedef struct packed {
    logic                start;
    logic [DiffBits-1:0] num;
    logic [DiffBits-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [TBits+2:0]    quo;   // signed, saturated to +-3.0
  } div_rsp_t;

endpackage

// ===== rtl/sbne_div.sv =====
// bit serial signed divider giving num * 65536 / den, truncated, saturated to +-3.0
module sbne_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbne_pkg::div_req_t req_i,
  output sbne_pkg::div_rsp_t rsp_o
);
  import sbne_pkg::*;

  localparam int Steps = DiffBits + 16;

  logic                busy_q, busy_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic [DiffBits:0]   rem_q, rem_d;
  logic [DiffBits-1:0] dvd_q, dvd_d;   // dividend shifted out one bit a cycle
  logic [DiffBits-1:0] den_q, den_d;
  logic [QBits-1:0]    quo_q, quo_d;
  logic                ovf_q, ovf_d;
  logic                neg_q, neg_d;
  logic                done_q, done_d;
  logic [DiffBits:0]   rem_sh;
  logic [DiffBits-1:0] num_mag, den_mag;
  logic [TBits+1:0]    res_mag;

  assign num_mag = req_i.num[DiffBits-1] ? DiffBits'(-req_i.num) : req_i.num;
  assign den_mag = req_i.den[DiffBits-1] ? DiffBits'(-req_i.den) : req_i.den;
  assign rem_sh  = {rem_q[DiffBits-1:0], dvd_q[DiffBits-1]};

  // one restoring step per cycle over the dividend bits then 16 zero bits
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    den_d  = den_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = num_mag;
      den_d  = den_mag;
      quo_d  = '0;
      ovf_d  = 1'b0;
      neg_d  = req_i.num[DiffBits-1] ^ req_i.den[DiffBits-1];
    end else if (busy_q) begin
      dvd_d = {dvd_q[DiffBits-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[QBits-2:0], 1'b1};
        ovf_d = ovf_q | quo_q[QBits-1] | (quo_q[QBits-2] & quo_q[QBits-3]);
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[QBits-2:0], 1'b0};
        ovf_d = ovf_q | quo_q[QBits-1];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntBits'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // saturate on overflow or when the integer part reaches 3
  always_comb begin
    if (ovf_q || quo_q[QBits-1:16] == 2'd3) res_mag = TSat;
    else res_mag = (TBits+2)'(quo_q);
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -{1'b0, res_mag} : {1'b0, res_mag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    den_q <= den_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
    neg_q <= neg_d;
  end

endmodule

// ===== rtl/segment_box_nearest_entry.sv =====
// top level: nearest box entry along a configured 3d segment
//
// The segment start, end and tolerance are written through the register
// port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must write them only
// while the block is idle, the block itself does not enforce it. Boxes then
// arrive on the input channel (in_valid_i / in_stall_o), one word each.
// Each box is tested one axis at a time: the two slab parameters of an axis
// come from one shared bit serial divider. Parallel axes and empty markers
// skip the divider. A word with last_box set produces one result word on
// the output channel (out_valid_o / out_stall_i); on a hit the clip point is
// start plus delta times t, formed by a shift and add multiplier per axis,
// else it is the segment end. While a result waits under out_stall_i the
// next box is already accepted and tested; only a second last_box waits.
// The short segment check sums one axis square at a time. Reset sets start
// and end to zero, tolerance to one, clears the kept entry and drops
// out_valid_o.
module segment_box_nearest_entry (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sbne_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [sbne_pkg::CoordBits-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sbne_pkg::CoordBits-1:0] box_min_x_i,
  input  logic signed [sbne_pkg::CoordBits-1:0] box_min_y_i,
  input  logic signed [sbne_pkg::CoordBits-1:0] box_min_z_i,
  input  logic signed [sbne_pkg::CoordBits-1:0] box_max_x_i,
  input  logic signed [sbne_pkg::CoordBits-1:0] box_max_y_i,
  input  logic signed [sbne_pkg::CoordBits-1:0] box_max_z_i,
  input  logic                                box_present_i,
  input  logic                                last_box_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sbne_pkg::CoordBits-1:0] clip_x_o,
  output logic signed [sbne_pkg::CoordBits-1:0] clip_y_o,
  output logic signed [sbne_pkg::CoordBits-1:0] clip_z_o,
  output logic                                hit_o,
  output logic [sbne_pkg::TBits-1:0]          entry_t_o
);
  import sbne_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StAxis  = 8'b00000010,
    StDivLo = 8'b00000100,
    StDivHi = 8'b00001000,
    StShort = 8'b00010000,
    StMul   = 8'b00100000,
    StOut   = 8'b01000000,
    StNext  = 8'b10000000
  } state_e;

  localparam int SqBits  = 2 * TolBits + 2;
  localparam int MulCnt  = $clog2(TBits + 1);

  state_e state_q, state_d;

  // configuration
  logic signed [CoordBits-1:0] start_q [3];
  logic signed [CoordBits-1:0] end_q [3];
  logic [TolBits-1:0]          tol_q;

  // box word held during test
  logic signed [CoordBits-1:0] bmin_q [3], bmax_q [3];
  logic                        last_q, last_d;
  logic [1:0]                  axis_q, axis_d;
  logic                        miss_q, miss_d;
  logic signed [TBits+2:0]     tlo_q, tlo_d, thi_q, thi_d, t1_q, t1_d;

  // kept entry
  logic [TBits-1:0] near_q, near_d;
  logic             any_q, any_d;

  // result build
  logic [MulCnt-1:0]  mcnt_q, mcnt_d;
  logic [TBits-1:0]   mt_q, mt_d;           // multiplier bits shifted out
  logic [DiffBits+TBits-1:0] acc_q, acc_d;  // magnitude product
  logic [SqBits-1:0]  sum_q, sum_d;
  logic               long_q, long_d;       // segment not short
  logic signed [CoordBits-1:0] res_q [3], res_d [3];
  logic               ovalid_q, ovalid_d;
  logic               ohit_q, ohit_d;
  logic [TBits-1:0]   ot_q, ot_d;

  // divider
  div_req_t dreq;
  div_rsp_t drsp;

  logic signed [DiffBits-1:0] delta_a, smin_a, smax_a;
  logic [DiffBits-1:0]        dmag_a;
  logic                       par_a;
  logic [TolBits-1:0]         dm_narrow;
  logic [SqBits-1:0]          sq_a;
  logic signed [TBits+2:0]    quo_s;
  logic signed [TBits+2:0]    lo_n, hi_n, tlo_n, thi_n;
  logic                       in_acc;
  logic signed [DiffBits:0]   clip_s;

  sbne_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // per-axis view of the current axis
  assign delta_a   = DiffBits'(end_q[axis_q]) - DiffBits'(start_q[axis_q]);
  assign smin_a    = DiffBits'(bmin_q[axis_q]) - DiffBits'(start_q[axis_q]);
  assign smax_a    = DiffBits'(bmax_q[axis_q]) - DiffBits'(start_q[axis_q]);
  assign dmag_a    = delta_a[DiffBits-1] ? DiffBits'(-delta_a) : delta_a;
  assign par_a     = dmag_a <= DiffBits'(tol_q);
  assign dm_narrow = dmag_a[TolBits-1:0];
  assign sq_a      = SqBits'(dm_narrow * dm_narrow);
  assign quo_s     = drsp.quo;

  // slab ordering and interval update
  always_comb begin
    lo_n  = (t1_q > quo_s) ? quo_s : t1_q;
    hi_n  = (t1_q > quo_s) ? t1_q : quo_s;
    tlo_n = (lo_n > tlo_q) ? lo_n : tlo_q;
    thi_n = (hi_n < thi_q) ? hi_n : thi_q;
  end

  assign in_acc = in_valid_i && !in_stall_o;
  assign clip_s = delta_a[DiffBits-1]
                ? (DiffBits+1)'(start_q[axis_q]) - (DiffBits+1)'(acc_q[DiffBits+TBits-1:16])
                : (DiffBits+1)'(start_q[axis_q]) + (DiffBits+1)'(acc_q[DiffBits+TBits-1:16]);

  // test sequencer
  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    axis_d   = axis_q;
    miss_d   = miss_q;
    tlo_d    = tlo_q;
    thi_d    = thi_q;
    t1_d     = t1_q;
    near_d   = near_q;
    any_d    = any_q;
    mcnt_d   = mcnt_q;
    mt_d     = mt_q;
    acc_d    = acc_q;
    sum_d    = sum_q;
    long_d   = long_q;
    res_d    = res_q;
    ovalid_d = ovalid_q && out_stall_i;
    ohit_d   = ohit_q;
    ot_d     = ot_q;
    dreq.start = 1'b0;
    dreq.num   = smin_a;
    dreq.den   = delta_a;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          last_d = last_box_i;
          axis_d = '0;
          miss_d = !box_present_i;
          tlo_d  = '0;
          thi_d  = (TBits+3)'(TOne);
          state_d = box_present_i ? StAxis : StNext;
        end
      end
      StAxis: begin
        if (par_a) begin
          if (smin_a > 0 || smax_a < 0) begin
            miss_d  = 1'b1;
            state_d = StNext;
          end else if (axis_q == 2'd2) begin
            state_d = StNext;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end else begin
          dreq.start = 1'b1;
          state_d = StDivLo;
        end
      end
      StDivLo: begin
        if (drsp.done) begin
          t1_d = quo_s;
          dreq.start = 1'b1;
          dreq.num   = smax_a;
          state_d = StDivHi;
        end
      end
      StDivHi: begin
        if (drsp.done) begin
          tlo_d = tlo_n;
          thi_d = thi_n;
          if (tlo_n > thi_n) begin
            miss_d  = 1'b1;
            state_d = StNext;
          end else if (axis_q == 2'd2) begin
            state_d = StNext;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = StAxis;
          end
        end
      end
      StNext: begin
        // fold the box into the kept entry
        if (!miss_q && TBits'(tlo_q) < near_q) begin
          near_d = TBits'(tlo_q);
          any_d  = 1'b1;
        end
        if (!last_q) begin
          state_d = StIdle;
        end else if (!ovalid_d) begin
          // result build waits until the output word is free
          axis_d = '0;
          sum_d  = '0;
          long_d = 1'b0;
          state_d = StShort;
        end
      end
      StShort: begin
        // one axis square per cycle
        if (!par_a) long_d = 1'b1;
        sum_d = sum_q + sq_a;
        if (axis_q == 2'd2) begin
          axis_d = '0;
          mcnt_d = '0;
          mt_d   = near_q;
          acc_d  = '0;
          state_d = StMul;
        end else begin
          axis_d = axis_q + 1'b1;
        end
      end
      StMul: begin
        // shift and add, one t bit per cycle, lsb first
        if (mcnt_q == MulCnt'(TBits)) begin
          res_d[axis_q] = CoordBits'(clip_s);
          mcnt_d = '0;
          mt_d   = near_q;
          acc_d  = '0;
          if (axis_q == 2'd2) state_d = StOut;
          else axis_d = axis_q + 1'b1;
        end else begin
          acc_d  = (mt_q[0] ? acc_q + ((DiffBits+TBits)'(dmag_a) << TBits) : acc_q) >> 1;
          mt_d   = mt_q >> 1;
          mcnt_d = mcnt_q + 1'b1;
        end
      end
      StOut: begin
        if (!ovalid_d) begin
          ovalid_d = 1'b1;
          if (any_q && (long_q || sum_q > SqBits'(tol_q * tol_q))) begin
            ohit_d = 1'b1;
            ot_d   = near_q;
          end else begin
            ohit_d = 1'b0;
            ot_d   = TOne;
            for (int i = 0; i < 3; i++) res_d[i] = end_q[i];
          end
          near_d = TOne;
          any_d  = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign clip_x_o    = res_q[0];
  assign clip_y_o    = res_q[1];
  assign clip_z_o    = res_q[2];
  assign hit_o       = ohit_q;
  assign entry_t_o   = ot_q;

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      near_q   <= TOne;
      any_q    <= 1'b0;
      ovalid_q <= 1'b0;
      tol_q    <= TolBits'(1);
      for (int i = 0; i < 3; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
    end else begin
      state_q  <= state_d;
      near_q   <= near_d;
      any_q    <= any_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegStartX: start_q[0] <= cfg_data_i;
          RegStartY: start_q[1] <= cfg_data_i;
          RegStartZ: start_q[2] <= cfg_data_i;
          RegEndX:   end_q[0]   <= cfg_data_i;
          RegEndY:   end_q[1]   <= cfg_data_i;
          RegEndZ:   end_q[2]   <= cfg_data_i;
          RegTol:    tol_q      <= cfg_data_i[TolBits-1:0];
          default:   ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bmin_q[0] <= box_min_x_i;
      bmin_q[1] <= box_min_y_i;
      bmin_q[2] <= box_min_z_i;
      bmax_q[0] <= box_max_x_i;
      bmax_q[1] <= box_max_y_i;
      bmax_q[2] <= box_max_z_i;
    end
    last_q <= last_d;
    axis_q <= axis_d;
    miss_q <= miss_d;
    tlo_q  <= tlo_d;
    thi_q  <= thi_d;
    t1_q   <= t1_d;
    mcnt_q <= mcnt_d;
    mt_q   <= mt_d;
    acc_q  <= acc_d;
    sum_q  <= sum_d;
    long_q <= long_d;
    res_q  <= res_d;
    ohit_q <= ohit_d;
    ot_q   <= ot_d;
  end

  // checks
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_t_o))
    else $error("result dropped under stall");
  a_nohit_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> entry_t_o == TOne)
    else $error("miss result with entry t not one");
  a_hit_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> entry_t_o <= TOne)
    else $error("entry t above one");
  a_near_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> near_q == TOne)
    else $error("kept entry set without a hit");

endmodule

// ===== dv/tb_top.sv =====
// self-checking bench for the segment box nearest entry block
module tb_top;
  import sbne_pkg::*;

  localparam int WdogLimit = 20000;
  localparam int Drain     = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CoordBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CoordBits-1:0] box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  logic signed [CoordBits-1:0] box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  logic box_present_i = 1'b0;
  logic last_box_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CoordBits-1:0] clip_x_o, clip_y_o, clip_z_o;
  logic hit_o;
  logic [TBits-1:0] entry_t_o;

  segment_box_nearest_entry u_dut (.*);

  typedef struct {
    logic signed [CoordBits-1:0] x, y, z;
    logic                        hit;
    logic [TBits-1:0]            t;
  } clip_word_t;

  // predictor copy of configuration and kept entry
  longint seg_start[3], seg_end[3];
  longint seg_tol;
  longint kept_t;
  bit     kept_hit;

  clip_word_t clip_queue[$];
  int  n_fail, n_words, n_results, n_hits;
  int  send_idle_pct, recv_idle_pct;
  int  idle_cnt = 0;

  initial forever #2 clk_i = ~clk_i;

  function automatic longint sx(logic [CoordBits-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // (num * 65536) / den truncated, saturated at +-3.0
  function automatic longint slab_t(longint num, longint den);
    longint n, d, q, r, f;
    n = abs64(num); d = abs64(den);
    q = n / d; r = n % d;
    if (q >= 3) f = 3 * 65536;
    else f = (q << 16) | ((r << 16) / d);
    return ((num < 0) != (den < 0)) ? -f : f;
  endfunction

  function automatic longint scale_t(longint delta, longint t);
    longint m, p;
    m = abs64(delta);
    p = (m >> 16) * t + (((m & 64'hFFFF) * t) >> 16);
    return delta < 0 ? -p : p;
  endfunction

  function automatic bit seg_is_short();
    longint m, acc;
    acc = 0;
    for (int a = 0; a < 3; a++) begin
      m = abs64(seg_end[a] - seg_start[a]);
      if (m > seg_tol) return 1'b0;
      acc += m * m;
    end
    return acc <= seg_tol * seg_tol;
  endfunction

  // slab test of one box; returns hit and entry t
  function automatic bit box_entry_t(longint bmin[3], longint bmax[3], output longint t_in);
    longint lo, hi, d, t1, t2, s;
    lo = 0; hi = 65536; t_in = 0;
    for (int a = 0; a < 3; a++) begin
      d = seg_end[a] - seg_start[a];
      if (abs64(d) <= seg_tol) begin
        if (seg_start[a] < bmin[a] || seg_start[a] > bmax[a]) return 1'b0;
      end else begin
        t1 = slab_t(bmin[a] - seg_start[a], d);
        t2 = slab_t(bmax[a] - seg_start[a], d);
        if (t1 > t2) begin s = t1; t1 = t2; t2 = s; end
        if (t1 > lo) lo = t1;
        if (t2 < hi) hi = t2;
        if (lo > hi) return 1'b0;
      end
    end
    t_in = lo;
    return 1'b1;
  endfunction

  // update kept entry and queue the clip point on a last word
  task automatic predict_box(logic [CoordBits-1:0] mn[3], logic [CoordBits-1:0] mx[3],
                             bit present, bit last);
    longint bmin[3], bmax[3], t;
    clip_word_t w;
    bit use_hit;
    longint c[3];
    if (present) begin
      for (int a = 0; a < 3; a++) begin bmin[a] = sx(mn[a]); bmax[a] = sx(mx[a]); end
      if (box_entry_t(bmin, bmax, t) && t < kept_t) begin
        kept_t = t; kept_hit = 1'b1;
      end
    end
    if (last) begin
      use_hit = kept_hit && !seg_is_short();
      for (int a = 0; a < 3; a++)
        c[a] = use_hit ? seg_start[a] + scale_t(seg_end[a] - seg_start[a], kept_t) : seg_end[a];
      w.x = c[0][CoordBits-1:0]; w.y = c[1][CoordBits-1:0]; w.z = c[2][CoordBits-1:0];
      w.hit = use_hit;
      w.t = use_hit ? kept_t[TBits-1:0] : TOne;
      clip_queue = {clip_queue, w};
      kept_t = 65536; kept_hit = 1'b0;
    end
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CoordBits-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= RegStartZ) seg_start[idx] = sx(val);
    else if (idx <= RegEndZ) seg_end[idx - RegEndX] = sx(val);
    else if (idx == RegTol) seg_tol = val[TolBits-1:0];
  endtask

  // wait until the block is idle before reconfiguring
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (clip_queue.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic set_segment(logic [CoordBits-1:0] s[3], logic [CoordBits-1:0] e[3],
                             logic [TolBits-1:0] tol);
    drain_results();
    write_reg(RegStartX, s[0]); write_reg(RegStartY, s[1]); write_reg(RegStartZ, s[2]);
    write_reg(RegEndX, e[0]);   write_reg(RegEndY, e[1]);   write_reg(RegEndZ, e[2]);
    write_reg(RegTol, {{(CoordBits-TolBits){1'b0}}, tol});
  endtask

  // send one box word and wait for acceptance; valid drops only while idling
  task automatic send_box(logic [CoordBits-1:0] mn[3], logic [CoordBits-1:0] mx[3],
                          bit present, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    box_min_x_i <= mn[0]; box_min_y_i <= mn[1]; box_min_z_i <= mn[2];
    box_max_x_i <= mx[0]; box_max_y_i <= mx[1]; box_max_z_i <= mx[2];
    box_present_i <= present; last_box_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_box(mn, mx, present, last);
    n_words++;
  endtask

  function automatic logic [CoordBits-1:0] rand_coord(bit wide);
    if (wide) return $urandom();
    return CoordBits'(signed'($urandom_range(20 << 16) - (10 << 16)));
  endfunction

  // random box near the origin, sometimes inverted, wild or empty
  task automatic send_rand_box(bit last);
    logic [CoordBits-1:0] mn[3], mx[3];
    logic [CoordBits-1:0] a, b;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      a = rand_coord(mode == 0); b = rand_coord(mode == 0);
      if (mode != 1 && signed'(a) > signed'(b)) begin mn[i] = b; mx[i] = a; end
      else begin mn[i] = a; mx[i] = b; end
    end
    send_box(mn, mx, $urandom_range(15) != 0, last);
  endtask

  // stall and check process
  always @(posedge clk_i) begin
    clip_word_t w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (clip_queue.size() == 0) begin
          $error("unexpected result word"); n_fail++;
        end else begin
          w = clip_queue.pop_front();
          if (hit_o) n_hits++;
          if (clip_x_o !== w.x) begin $error("clip_x exp %0h got %0h", w.x, clip_x_o); n_fail++; end
          if (clip_y_o !== w.y) begin $error("clip_y exp %0h got %0h", w.y, clip_y_o); n_fail++; end
          if (clip_z_o !== w.z) begin $error("clip_z exp %0h got %0h", w.z, clip_z_o); n_fail++; end
          if (hit_o !== w.hit) begin $error("hit exp %0b got %0b", w.hit, hit_o); n_fail++; end
          if (entry_t_o !== w.t) begin $error("entry_t exp %0d got %0d", w.t, entry_t_o); n_fail++; end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WdogLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    logic [CoordBits-1:0] s[3], e[3], mn[3], mx[3];
    s = '{32'h0, 32'h0, 32'h0}; e = '{32'h000A_0000, 32'h0, 32'h0};
    set_segment(s, e, 16'd1);
    mn = '{32'h0002_0000, 32'hFFFF_0000, 32'hFFFF_0000};
    mx = '{32'h0003_0000, 32'h0001_0000, 32'h0001_0000};
    send_box(mn, mx, 1, 0);
    mn[0] = 32'h0005_0000; mx[0] = 32'h0006_0000;
    send_box(mn, mx, 1, 1);                     // nearest kept
    mn[1] = 32'h0002_0000; mx[1] = 32'h0003_0000;
    send_box(mn, mx, 1, 1);                     // parallel axis miss
    send_box(mn, mx, 0, 1);                     // empty marker
    mn = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
    mx = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    send_box(mn, mx, 1, 1);                     // start inside box
    mn[1] = 32'h0001_0000; mx[1] = 32'hFFFF_0000;
    send_box(mn, mx, 1, 1);                     // inverted on parallel axis
    mn = '{32'h0003_0000, 32'hFFFF_0000, 32'hFFFF_0000};
    mx = '{32'h0002_0000, 32'h0001_0000, 32'h0001_0000};
    send_box(mn, mx, 1, 1);                     // inverted on moving axis
    mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    mx = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_box(mn, mx, 1, 1);                     // extreme corners
    // extreme segment, tolerance max
    s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    e = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    set_segment(s, e, 16'hFFFF);
    send_box(mn, mx, 1, 1);
    mn = '{32'h0, 32'h0, 32'h0}; mx = '{32'h0010_0000, 32'h0010_0000, 32'h0010_0000};
    send_box(mn, mx, 1, 1);
    // short segment whose box test hits
    s = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    e = '{32'h0001_4000, 32'h0001_0000, 32'h0001_0000};
    set_segment(s, e, 16'hFFFF);
    mn = '{32'h0, 32'h0, 32'h0}; mx = '{32'h0002_0000, 32'h0002_0000, 32'h0002_0000};
    send_box(mn, mx, 1, 1);
    // zero tolerance
    s = '{32'h0, 32'h0, 32'h0}; e = '{32'h0004_0000, 32'h0004_0000, 32'h0};
    set_segment(s, e, 16'd0);
    send_box(mn, mx, 1, 1);
  endtask

  task automatic test_random(int n_items);
    logic [CoordBits-1:0] s[3], e[3];
    int sent;
    sent = 0;
    while (sent < n_items) begin
      for (int i = 0; i < 3; i++) begin
        s[i] = rand_coord($urandom_range(7) == 0);
        e[i] = ($urandom_range(5) == 0) ? s[i] + $urandom_range(3) : rand_coord($urandom_range(7) == 0);
      end
      set_segment(s, e, ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(4)));
      repeat (8) begin
        int len;
        len = $urandom_range(4);
        for (int k = 0; k <= len; k++) begin
          send_rand_box((k == len) || ($urandom_range(19) == 0));
          sent++;
        end
      end
    end
  endtask

  initial begin
    seg_start = '{0, 0, 0}; seg_end = '{0, 0, 0}; seg_tol = 1;
    kept_t = 65536; kept_hit = 1'b0;
    n_fail = 0; n_words = 0; n_results = 0; n_hits = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    send_idle_pct = 34; recv_idle_pct = 65;
    test_random(170);
    send_idle_pct = 65; recv_idle_pct = 34;
    test_random(170);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(170);
    drain_results();
    $display("covered %0d box words, %0d clip results (%0d hits) over several segments",
             n_words, n_results, n_hits);
    if (clip_queue.size() != 0) n_fail++;
    if (n_fail == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
